// ===== rtl/core/trdec_pkg.sv =====
// Shared types and constants of the TGA RLE pixel decoder.
package trdec_pkg;

   localparam logic [7:0] HDR_RUN_BIT    = 8'h80;
   localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;

   localparam logic [1:0] REG_PIXEL_BYTES  = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

   localparam logic [2:0] PIXEL_BYTES_BGRA = 3'd4;
   localparam logic [2:0] PIXEL_BYTES_RST  = 3'd3;

   localparam int TOKEN_DEPTH = 2;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] count;
      logic       done;
   } token_type;

   typedef struct packed {
      logic        four_byte;
      logic [31:0] total;
   } cfg_type;

endpackage

// ===== rtl/core/trdec_csr.sv =====
// Configuration registers and pixel total of the TGA RLE pixel decoder.
module trdec_csr
   import trdec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [2:0]  pixel_bytes_ff, pixel_bytes_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] total_ff, total_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      pixel_bytes_in = pixel_bytes_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PIXEL_BYTES:  pixel_bytes_in = csr_pwdata[2:0];
            REG_IMAGE_WIDTH:  width_in       = csr_pwdata[15:0];
            REG_IMAGE_HEIGHT: height_in      = csr_pwdata[15:0];
            default: ;
         endcase
      end
      total_in = 32'(width_in) * 32'(height_in);
   end

   always_comb begin
      case (reg_idx)
         REG_PIXEL_BYTES:  csr_prdata = {29'd0, pixel_bytes_ff};
         REG_IMAGE_WIDTH:  csr_prdata = {16'd0, width_ff};
         REG_IMAGE_HEIGHT: csr_prdata = {16'd0, height_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bytes_ff <= PIXEL_BYTES_RST;
         width_ff       <= 16'd1;
         height_ff      <= 16'd1;
         total_ff       <= 32'd1;
      end else begin
         pixel_bytes_ff <= pixel_bytes_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         total_ff       <= total_in;
      end
   end

   assign cfg.four_byte = (pixel_bytes_ff == PIXEL_BYTES_BGRA);
   assign cfg.total     = total_ff;

endmodule

// ===== rtl/core/trdec_front.sv =====
// Packet parser: splits headers from pixel bytes, assembles and counts pixels.
module trdec_front
   import trdec_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      in_valid,
   input  logic      in_ready,
   input  logic [7:0] in_byte,
   input  logic      in_start,
   output logic      push,
   output token_type token
);

   logic        expect_ff, expect_in;
   logic        is_run_ff, is_run_in;
   logic [7:0]  left_ff, left_in;
   logic [1:0]  bip_ff, bip_in;
   logic [23:0] gather_ff, gather_in;
   logic [31:0] decoded_ff, decoded_in;
   logic        finished_ff, finished_in;
   logic        accept, live, work, hdr, last_byte, done;
   logic [23:0] gather_next;
   logic [7:0]  left_dec, count, clipped;
   logic [31:0] missing;

   assign accept    = in_valid & in_ready;
   // bytes after the image are dropped until a restart
   assign live      = in_start | ~(finished_ff | (decoded_ff >= cfg.total));
   assign work      = accept & live & (cfg.total != 32'd0);
   assign hdr       = in_start | expect_ff;
   assign last_byte = cfg.four_byte ? (bip_ff == 2'd3) : (bip_ff >= 2'd2);
   assign left_dec  = left_ff - 8'd1;
   assign count     = (is_run_ff && left_ff != 8'd0) ? left_ff : 8'd1;
   assign missing   = cfg.total - decoded_ff;
   assign done      = ({24'd0, count} >= missing);
   assign clipped   = done ? missing[7:0] : count;

   always_comb begin
      case (bip_ff)
         2'd0:    gather_next = gather_ff | {16'd0, in_byte};
         2'd1:    gather_next = gather_ff | {8'd0, in_byte, 8'd0};
         2'd2:    gather_next = gather_ff | {in_byte, 16'd0};
         default: gather_next = gather_ff;
      endcase
   end

   assign push = work & ~hdr & last_byte;

   always_comb begin
      token.red   = gather_next[23:16];
      token.green = gather_next[15:8];
      token.blue  = gather_next[7:0];
      token.alpha = (cfg.four_byte && bip_ff == 2'd3) ? in_byte : 8'd0;
      token.count = clipped;
      token.done  = done;
   end

   always_comb begin
      expect_in   = expect_ff;
      is_run_in   = is_run_ff;
      left_in     = left_ff;
      bip_in      = bip_ff;
      gather_in   = gather_ff;
      decoded_in  = decoded_ff;
      finished_in = finished_ff;
      if (accept && in_start) begin
         expect_in   = 1'b1;
         is_run_in   = 1'b0;
         left_in     = 8'd0;
         bip_in      = 2'd0;
         gather_in   = 24'd0;
         decoded_in  = 32'd0;
         finished_in = 1'b0;
      end
      if (work) begin
         if (hdr) begin
            is_run_in = (in_byte & HDR_RUN_BIT) != 8'd0;
            left_in   = (in_byte & HDR_COUNT_MASK) + 8'd1;
            bip_in    = 2'd0;
            gather_in = 24'd0;
            expect_in = 1'b0;
         end else if (!last_byte) begin
            bip_in    = bip_ff + 2'd1;
            gather_in = gather_next;
         end else begin
            bip_in      = 2'd0;
            gather_in   = 24'd0;
            decoded_in  = decoded_ff + {24'd0, clipped};
            finished_in = done;
            if (is_run_ff) begin
               left_in   = 8'd0;
               expect_in = 1'b1;
            end else begin
               left_in   = left_dec;
               expect_in = (left_dec == 8'd0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff   <= 1'b1;
         is_run_ff   <= 1'b0;
         left_ff     <= 8'd0;
         bip_ff      <= 2'd0;
         gather_ff   <= 24'd0;
         decoded_ff  <= 32'd0;
         finished_ff <= 1'b0;
      end else begin
         expect_ff   <= expect_in;
         is_run_ff   <= is_run_in;
         left_ff     <= left_in;
         bip_ff      <= bip_in;
         gather_ff   <= gather_in;
         decoded_ff  <= decoded_in;
         finished_ff <= finished_in;
      end
   end

endmodule

// ===== rtl/core/trdec_queue.sv =====
// Two-entry pixel token queue between parser and result stage.
module trdec_queue
   import trdec_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_token,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output token_type head,
   output logic [1:0] level
);

   token_type  mem_ff [TOKEN_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] level_ff, level_in;

   assign full      = (level_ff == 2'(TOKEN_DEPTH));
   assign not_empty = (level_ff != 2'd0);
   assign head      = mem_ff[rd_ptr_ff];
   assign level     = level_ff;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

// ===== rtl/core/trdec_back.sv =====
// Result stage: holds one pixel on the output until it is taken.
module trdec_back
   import trdec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       tok_valid,
   input  token_type  tok,
   output logic       tok_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic       rsp_tlast
);

   logic        valid_ff, valid_in;
   logic [39:0] data_ff, data_in;
   logic        last_ff, last_in;
   logic        adv;

   assign adv     = ~valid_ff | rsp_tready;
   assign tok_pop = tok_valid & adv;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (adv) begin
         valid_in = tok_valid;
      end
      if (tok_pop) begin
         data_in = {tok.count, tok.alpha, tok.blue, tok.green, tok.red};
         last_in = tok.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== rtl/core/tga_rle_pixel_decoder.sv =====
// Top level of the TGA RLE pixel decoder.
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata: data_byte; tuser: frame_start
// rsp      out  rsp_tvalid/rsp_tready  tdata: red,green,blue,alpha,repeat_count;
//                                      tlast: image_done
// csr      in   psel/penable/pready    pixel_bytes @0, image_width @4, image_height @8
//
// One byte per cycle in while the token queue has room. Once the last byte of a pixel
// is accepted, the pixel passes the token queue, then the result register, to rsp_tvalid.
// The parser counts pixels and stalls only when the two-entry token queue is full.
// Reset is synchronous; decoding restarts at the first header byte.
// The pixel total is registered from width*height at the write itself.
module tga_rle_pixel_decoder
   import trdec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                    // [31:24] alpha, [39:32] repeat_count
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg;
   token_type  push_token, head;
   logic       push, pop, q_full, q_valid;
   logic [1:0] q_level;

   assign req_tready = ~q_full;

   trdec_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   trdec_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_start (req_tuser),
      .push     (push),
      .token    (push_token)
   );

   trdec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_valid),
      .head       (head),
      .level      (q_level)
   );

   trdec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (q_valid),
      .tok        (head),
      .tok_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:32] != 8'd0)
      else $error("result with zero repeat count");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= 2'(TOKEN_DEPTH))
      else $error("token queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("token pushed into full queue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && q_level == 2'd0)
      else $error("state not cleared by reset");

endmodule
